### design/pewc_pkg.sv
// ----------------------------------------------------------------------------
// pewc_pkg
// Shared types and constants of the pixel element widen/convert unit.
// ----------------------------------------------------------------------------
package pewc_pkg;

    localparam logic [1:0] MODE_U16_U32  = 2'd0;
    localparam logic [1:0] MODE_U32_F32  = 2'd1;
    localparam logic [1:0] MODE_HALF_F32 = 2'd2;
    localparam logic [1:0] MODE_PASS     = 2'd3;

    localparam logic [7:0] SINGLE_BIAS   = 8'd127;
    localparam logic [7:0] SUBN_EXP_BASE = 8'd113;
    localparam logic [7:0] EXP_ALL_ONES  = 8'hFF;
    localparam logic [4:0] HALF_EXP_MAX  = 5'h1F;
    localparam logic [7:0] HALF_REBIAS   = 8'd112;

    typedef struct packed {
        logic [31:0] element;
        logic        row_end;
        logic        frame_end;
    } t_item_in;

    typedef struct packed {
        logic [31:0] element;
        logic        row_end;
        logic        frame_end;
    } t_item_out;

    // Work carried from the normalize stage to the round/pack stage.
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] raw;       // passthrough / widen result
        logic        zero;
        logic [4:0]  msb_pos;   // leading one position of integer
        logic [31:0] norm;      // integer shifted so leading one sits at bit 31
        logic        row_end;
        logic        frame_end;
    } t_norm;

endpackage

### design/pewc_if.sv
// ----------------------------------------------------------------------------
// pewc_in_if / pewc_out_if
// Valid/ready channels that carry input and result items.
// ----------------------------------------------------------------------------
interface pewc_in_if;
    logic valid;
    logic ready;
    pewc_pkg::t_item_in payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pewc_out_if;
    logic valid;
    logic ready;
    pewc_pkg::t_item_out payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pewc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/pewc_norm.sv
// ----------------------------------------------------------------------------
// pewc_norm
// Stage 1: leading-one search and left normalize of the integer element,
// and the half widening path.
// ----------------------------------------------------------------------------
module pewc_norm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic               i_valid,
    input  logic [1:0]         i_mode,
    input  pewc_pkg::t_item_in i_item,
    output logic               o_valid,
    output pewc_pkg::t_norm    o_norm
);
    import pewc_pkg::*;

    logic [4:0]  lz;
    logic        found;
    logic [31:0] half_res;
    logic [4:0]  hexp;
    logic [9:0]  hman;
    logic [3:0]  hsh;
    logic        hfound;
    logic [9:0]  hman_n;
    t_norm       n_norm;
    logic        r_valid;
    t_norm       r_norm;

    always_comb begin
        lz = 5'd0;
        found = 1'b0;
        for (int k = 31; k >= 0; k--) begin
            if (!found && i_item.element[k]) begin
                found = 1'b1;
                lz = 5'(k);
            end
        end
    end

    always_comb begin
        hexp = i_item.element[14:10];
        hman = i_item.element[9:0];
        hsh = 4'd0;
        hfound = 1'b0;
        for (int k = 9; k >= 0; k--) begin
            if (!hfound && hman[k]) begin
                hfound = 1'b1;
                hsh = 4'(10 - k);
            end
        end
        hman_n = 10'(hman << hsh);
        if (hexp == 5'd0) begin
            if (hman == 10'd0) begin
                half_res = {i_item.element[15], 31'd0};
            end else begin
                half_res = {i_item.element[15], SUBN_EXP_BASE - {4'd0, hsh}, hman_n, 13'd0};
            end
        end else if (hexp == HALF_EXP_MAX) begin
            half_res = {i_item.element[15], EXP_ALL_ONES, hman, 13'd0};
        end else begin
            half_res = {i_item.element[15], {3'd0, hexp} + HALF_REBIAS, hman, 13'd0};
        end
    end

    always_comb begin
        n_norm.mode = i_mode;
        n_norm.zero = (i_item.element == 32'd0);
        n_norm.msb_pos = lz;
        n_norm.norm = i_item.element << (5'd31 - lz);
        n_norm.row_end = i_item.row_end;
        n_norm.frame_end = i_item.frame_end;
        case (i_mode)
            MODE_U16_U32:  n_norm.raw = {16'd0, i_item.element[15:0]};
            MODE_HALF_F32: n_norm.raw = half_res;
            default:       n_norm.raw = i_item.element;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_norm <= n_norm;
        end
    end

    assign o_valid = r_valid;
    assign o_norm = r_norm;
endmodule

### design/pewc_round.sv
// ----------------------------------------------------------------------------
// pewc_round
// Stage 2: round to nearest even and pack the single; select the result.
// ----------------------------------------------------------------------------
module pewc_round (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic                i_valid,
    input  pewc_pkg::t_norm     i_norm,
    output logic                o_valid,
    output pewc_pkg::t_item_out o_item
);
    import pewc_pkg::*;

    logic [23:0] keep;
    logic        guard;
    logic        sticky;
    logic        inc;
    logic [31:0] fbits;
    t_item_out   n_item;
    logic        r_valid;
    t_item_out   r_item;

    always_comb begin
        keep = i_norm.norm[31:8];
        guard = i_norm.norm[7];
        sticky = |i_norm.norm[6:0];
        inc = guard && (sticky || keep[0]);
        // Mantissa carry ripples into exponent by plain addition.
        fbits = {1'b0, SINGLE_BIAS + {3'd0, i_norm.msb_pos}, keep[22:0]}
              + {31'd0, inc};
        if (i_norm.zero) begin
            fbits = 32'd0;
        end
        n_item.row_end = i_norm.row_end;
        n_item.frame_end = i_norm.frame_end;
        if (i_norm.mode == MODE_U32_F32) begin
            n_item.element = fbits;
        end else begin
            n_item.element = i_norm.raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item = r_item;
endmodule

### design/pixel_element_widen_convert_unit.sv
// ----------------------------------------------------------------------------
// pixel_element_widen_convert_unit
// Converts one pixel channel element per item as set by the mode register.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output register is empty or being taken
// and returns one result item per item via an input register, a normalize stage
// (leading-one search, left shift, half widening) and a round/pack stage. The
// three registers advance together on that condition, so a stalled consumer
// holds the whole pipe without losing or repeating items.
// Mode: 0 zero-extend u16, 1 u32 to single (nearest even), 2 half to single,
// 3 pass the element through. Row and frame end marks travel unchanged.
// Write the mode only while the pipe is empty.
module pixel_element_widen_convert_unit (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pewc_cfg_if.sink  cfg,
    pewc_in_if.sink   in_ch,
    pewc_out_if.source out_ch
);
    import pewc_pkg::*;

    logic [1:0] r_mode;
    logic       advance;
    logic       r_in_valid;
    t_item_in   r_in_item;
    logic       norm_valid;
    t_norm      norm;

    // Move the whole pipe when the output slot is free or being drained.
    assign advance = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = advance;
    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_U16_U32;
        end else if (cfg.valid) begin
            r_mode <= cfg.data;
        end
    end

    // Input register: hold the accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_in_item <= in_ch.payload;
        end
    end

    pewc_norm u_norm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_valid   (r_in_valid),
        .i_mode    (r_mode),
        .i_item    (r_in_item),
        .o_valid   (norm_valid),
        .o_norm    (norm)
    );

    pewc_round u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_valid   (norm_valid),
        .i_norm    (norm),
        .o_valid   (out_ch.valid),
        .o_item    (out_ch.payload)
    );
endmodule

### design/pewc_checker.sv
// ----------------------------------------------------------------------------
// pewc_checker
// Port-level checks of the widen/convert unit.
// ----------------------------------------------------------------------------
module pewc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [33:0] out_payload
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result dropped under stall");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !out_valid)
        else $error("result right after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("item lost in pipe");
endmodule

bind pixel_element_widen_convert_unit pewc_checker u_pewc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload)
);
